### rtl/crrs_pkg.sv
// ----------------------------------------------------------------------------
// crrs_pkg
// Shared types and constants for the core link round-robin select unit.
// ----------------------------------------------------------------------------
package crrs_pkg;

    // Links are fixed by the per-link register layout (4 mask bits, 4 x 15 NRI bits)
    localparam int NUM_LINKS          = 4;
    localparam int LINK_W             = 2;
    localparam int PTR_W              = 3;
    localparam int NRI_W              = 15;
    localparam int NRI_CONTAINER_BITS = 10;
    localparam int NRI_OUT_W          = 16;
    localparam int CFG_DATA_W         = 60;
    localparam int CFG_IDX_W          = 3;
    localparam int BITLEN_W           = 4;
    localparam int NULL_RANGE_W       = 31;
    localparam int REASON_W           = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NRI_BIT_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NULL_NRI_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_NRI_FIRST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_NRI_LAST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_NRI_EN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_PRESENT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_ATTACH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_EMERG    = 3'd7;

    // Selection reason codes
    localparam logic [REASON_W-1:0] REASON_PAGING   = 3'd0;
    localparam logic [REASON_W-1:0] REASON_NRI      = 3'd1;
    localparam logic [REASON_W-1:0] REASON_RR_NEW   = 3'd2;
    localparam logic [REASON_W-1:0] REASON_RR_NULL  = 3'd3;
    localparam logic [REASON_W-1:0] REASON_NONE     = 3'd4;

    // NRI value reported when there is none (-1)
    localparam logic [NRI_OUT_W-1:0] NRI_NONE = 16'hFFFF;

    typedef struct packed {
        logic [BITLEN_W-1:0]        nri_bit_length;
        logic [NULL_RANGE_W-1:0]    null_nri_range;
        logic [NUM_LINKS*NRI_W-1:0] link_nri_first;
        logic [NUM_LINKS*NRI_W-1:0] link_nri_last;
        logic [NUM_LINKS-1:0]       link_nri_enable;
        logic [NUM_LINKS-1:0]       link_present_mask;
        logic [NUM_LINKS-1:0]       allow_attach_mask;
        logic [NUM_LINKS-1:0]       allow_emerg_mask;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic [NRI_W-1:0] value;
        logic             is_null;
    } t_nri;

    typedef struct packed {
        logic                 found;
        logic                 by_nri;
        logic [LINK_W-1:0]    link;
        logic [NUM_LINKS-1:0] lost_mask;
    } t_pick;

endpackage

### rtl/core_link_nri_round_robin_select_unit.sv
// ----------------------------------------------------------------------------
// core_link_nri_round_robin_select_unit
// Core link selection per request: paging match, NRI range, round-robin.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with one port per request field. A word
//   is taken on a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with one port per result field.
//   Config: i_cfg_we writes i_cfg_data into register i_cfg_index; write only
//   while no request is in flight.
//   Each request passes through the input register, then the result register.
//   Throughput: one request per cycle while the receiver does not stall; the
//   selection and the round-robin pointer update settle within the single
//   logic stage.
//   Reset (synchronous, active low) empties both stages, loads the register
//   defaults and clears the normal and emergency round-robin pointers.
//   When the receiver stalls, the result register holds its word and the
//   input register still fills; o_stall rises once both are occupied.
// ----------------------------------------------------------------------------
module core_link_nri_round_robin_select_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration
    input  logic                                     i_cfg_we,
    input  logic [crrs_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [crrs_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    // request channel
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic                                     i_is_paging_response,
    input  logic                                     i_paging_match_valid,
    input  logic [crrs_pkg::LINK_W-1:0]              i_paging_match_link,
    input  logic                                     i_nri_container_valid,
    input  logic [crrs_pkg::NRI_CONTAINER_BITS-1:0]  i_nri_container,
    input  logic                                     i_identity_is_tmsi,
    input  logic [31:0]                              i_tmsi,
    input  logic                                     i_from_other_plmn,
    input  logic                                     i_is_emergency,
    input  logic [crrs_pkg::NUM_LINKS-1:0]           i_link_ready_mask,
    // result channel
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic                                     o_link_found,
    output logic [crrs_pkg::LINK_W-1:0]              o_selected_link,
    output logic [crrs_pkg::REASON_W-1:0]            o_select_reason,
    output logic signed [crrs_pkg::NRI_OUT_W-1:0]    o_nri_value,
    output logic [crrs_pkg::NUM_LINKS-1:0]           o_attach_lost_mask,
    output logic                                     o_emergency_forwarded,
    output logic                                     o_emergency_lost
);
    import crrs_pkg::*;

    t_cfg cfg;
    t_nri nri;
    t_pick pick;

    // input stage
    logic                          r_in_valid;
    logic                          r_is_paging_response;
    logic                          r_paging_match_valid;
    logic [LINK_W-1:0]             r_paging_match_link;
    logic                          r_nri_container_valid;
    logic [NRI_CONTAINER_BITS-1:0] r_nri_container;
    logic                          r_identity_is_tmsi;
    logic [31:0]                   r_tmsi;
    logic                          r_from_other_plmn;
    logic                          r_is_emergency;
    logic [NUM_LINKS-1:0]          r_link_ready_mask;

    // round-robin pointers
    logic [PTR_W-1:0]              r_next_normal;
    logic [PTR_W-1:0]              r_next_emerg;
    logic [PTR_W-1:0]              n_next_normal;
    logic [PTR_W-1:0]              n_next_emerg;

    // result stage
    logic                          r_out_valid;
    logic                          r_link_found;
    logic [LINK_W-1:0]             r_selected_link;
    logic [REASON_W-1:0]           r_select_reason;
    logic [NRI_OUT_W-1:0]          r_nri_value;
    logic [NUM_LINKS-1:0]          r_attach_lost_mask;
    logic                          r_emergency_forwarded;
    logic                          r_emergency_lost;

    logic                          n_link_found;
    logic [LINK_W-1:0]             n_selected_link;
    logic [REASON_W-1:0]           n_select_reason;
    logic [NRI_OUT_W-1:0]          n_nri_value;
    logic [NUM_LINKS-1:0]          n_attach_lost_mask;
    logic                          n_emergency_forwarded;
    logic                          n_emergency_lost;

    logic                          out_load;
    logic                          in_load;
    logic                          paging_hit;
    logic [PTR_W-1:0]              ptr;
    logic [PTR_W-1:0]              ptr_after;

    crrs_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    crrs_nri_extract u_nri_extract (
        .i_nri_container_valid (r_nri_container_valid),
        .i_nri_container       (r_nri_container),
        .i_identity_is_tmsi    (r_identity_is_tmsi),
        .i_tmsi                (r_tmsi),
        .i_from_other_plmn     (r_from_other_plmn),
        .i_cfg                 (cfg),
        .o_nri                 (nri)
    );

    assign ptr = r_is_emergency ? r_next_emerg : r_next_normal;

    crrs_link_pick u_link_pick (
        .i_cfg             (cfg),
        .i_nri             (nri),
        .i_is_emergency    (r_is_emergency),
        .i_link_ready_mask (r_link_ready_mask),
        .i_ptr             (ptr),
        .o_pick            (pick)
    );

    // Handshake: result register frees when taken, input register when it moves on
    assign out_load = !r_out_valid || !i_stall;
    assign in_load  = !r_in_valid || out_load;
    assign o_stall  = !in_load;

    // Capture the request word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_is_paging_response  <= i_is_paging_response;
            r_paging_match_valid  <= i_paging_match_valid;
            r_paging_match_link   <= i_paging_match_link;
            r_nri_container_valid <= i_nri_container_valid;
            r_nri_container       <= i_nri_container;
            r_identity_is_tmsi    <= i_identity_is_tmsi;
            r_tmsi                <= i_tmsi;
            r_from_other_plmn     <= i_from_other_plmn;
            r_is_emergency        <= i_is_emergency;
            r_link_ready_mask     <= i_link_ready_mask;
        end
    end

    // Build the result word and the pointer update
    assign paging_hit = r_is_paging_response && r_paging_match_valid
                        && cfg.link_present_mask[r_paging_match_link];
    assign ptr_after  = PTR_W'({1'b0, pick.link}) + PTR_W'(1);

    always_comb begin
        n_next_normal         = r_next_normal;
        n_next_emerg          = r_next_emerg;
        n_link_found          = 1'b0;
        n_selected_link       = '0;
        n_select_reason       = REASON_NONE;
        n_nri_value           = NRI_NONE;
        n_attach_lost_mask    = '0;
        n_emergency_forwarded = 1'b0;
        n_emergency_lost      = 1'b0;
        if (paging_hit) begin
            n_link_found    = 1'b1;
            n_selected_link = r_paging_match_link;
            n_select_reason = REASON_PAGING;
        end else begin
            n_nri_value        = nri.valid ? {1'b0, nri.value} : NRI_NONE;
            n_attach_lost_mask = pick.lost_mask;
            if (pick.found) begin
                n_link_found          = 1'b1;
                n_selected_link       = pick.link;
                n_emergency_forwarded = r_is_emergency;
                if (pick.by_nri) begin
                    n_select_reason = REASON_NRI;
                end else begin
                    n_select_reason = nri.is_null ? REASON_RR_NULL : REASON_RR_NEW;
                    if (r_is_emergency) begin
                        n_next_emerg = ptr_after;
                    end else begin
                        n_next_normal = ptr_after;
                    end
                end
            end else begin
                n_emergency_lost = r_is_emergency;
            end
        end
    end

    // Advance the pointers only when a request moves into the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_normal <= '0;
            r_next_emerg  <= '0;
        end else if (r_in_valid && out_load) begin
            r_next_normal <= n_next_normal;
            r_next_emerg  <= n_next_emerg;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_link_found          <= n_link_found;
            r_selected_link       <= n_selected_link;
            r_select_reason       <= n_select_reason;
            r_nri_value           <= n_nri_value;
            r_attach_lost_mask    <= n_attach_lost_mask;
            r_emergency_forwarded <= n_emergency_forwarded;
            r_emergency_lost      <= n_emergency_lost;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_link_found          = r_link_found;
    assign o_selected_link       = r_selected_link;
    assign o_select_reason       = r_select_reason;
    assign o_nri_value           = r_nri_value;
    assign o_attach_lost_mask    = r_attach_lost_mask;
    assign o_emergency_forwarded = r_emergency_forwarded;
    assign o_emergency_lost      = r_emergency_lost;

endmodule

### rtl/crrs_cfg_regs.sv
// ----------------------------------------------------------------------------
// crrs_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module crrs_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [crrs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [crrs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output crrs_pkg::t_cfg                   o_cfg
);
    import crrs_pkg::*;

    t_cfg r_cfg;

    // Load the addressed register, keep only its own bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nri_bit_length    <= BITLEN_W'(10);
            r_cfg.null_nri_range    <= '0;
            r_cfg.link_nri_first    <= '0;
            r_cfg.link_nri_last     <= '0;
            r_cfg.link_nri_enable   <= '0;
            r_cfg.link_present_mask <= NUM_LINKS'(1);
            r_cfg.allow_attach_mask <= '1;
            r_cfg.allow_emerg_mask  <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NRI_BIT_LENGTH: r_cfg.nri_bit_length    <= i_cfg_data[BITLEN_W-1:0];
                REG_NULL_NRI_RANGE: r_cfg.null_nri_range    <= i_cfg_data[NULL_RANGE_W-1:0];
                REG_LINK_NRI_FIRST: r_cfg.link_nri_first    <= i_cfg_data[NUM_LINKS*NRI_W-1:0];
                REG_LINK_NRI_LAST:  r_cfg.link_nri_last     <= i_cfg_data[NUM_LINKS*NRI_W-1:0];
                REG_LINK_NRI_EN:    r_cfg.link_nri_enable   <= i_cfg_data[NUM_LINKS-1:0];
                REG_LINK_PRESENT:   r_cfg.link_present_mask <= i_cfg_data[NUM_LINKS-1:0];
                REG_ALLOW_ATTACH:   r_cfg.allow_attach_mask <= i_cfg_data[NUM_LINKS-1:0];
                REG_ALLOW_EMERG:    r_cfg.allow_emerg_mask  <= i_cfg_data[NUM_LINKS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/crrs_nri_extract.sv
// ----------------------------------------------------------------------------
// crrs_nri_extract
// Derives the NRI from the container or the TMSI and checks the NULL range.
// ----------------------------------------------------------------------------
module crrs_nri_extract (
    input  logic                                      i_nri_container_valid,
    input  logic [crrs_pkg::NRI_CONTAINER_BITS-1:0]   i_nri_container,
    input  logic                                      i_identity_is_tmsi,
    input  logic [31:0]                               i_tmsi,
    input  logic                                      i_from_other_plmn,
    input  crrs_pkg::t_cfg                            i_cfg,
    output crrs_pkg::t_nri                            o_nri
);
    import crrs_pkg::*;

    logic [BITLEN_W-1:0] bitlen;
    logic [BITLEN_W-1:0] cont_shift;
    logic [NRI_CONTAINER_BITS-1:0] cont_val;
    logic [4:0]          tmsi_shift;
    logic [23:0]         tmsi_shifted;
    logic [NRI_W:0]      tmsi_mask;
    logic                nri_ok;
    logic [NRI_W-1:0]    nri_val;
    logic [NRI_W-1:0]    null_first;
    logic [NRI_W-1:0]    null_last;

    assign bitlen = i_cfg.nri_bit_length;

    // Container: drop the unused low bits when fewer than 10 bits are in use
    always_comb begin
        cont_shift = BITLEN_W'(NRI_CONTAINER_BITS) - bitlen;
        if (bitlen < BITLEN_W'(NRI_CONTAINER_BITS)) begin
            cont_val = i_nri_container >> cont_shift;
        end else begin
            cont_val = i_nri_container;
        end
    end

    // TMSI: take bitlen bits ending at bit 23
    assign tmsi_shift   = 5'd24 - {1'b0, bitlen};
    assign tmsi_shifted = i_tmsi[23:0] >> tmsi_shift;
    assign tmsi_mask    = ((NRI_W+1)'(1) << bitlen) - (NRI_W+1)'(1);

    // Pick the source, then drop it for other-network requests
    always_comb begin
        nri_ok  = 1'b0;
        nri_val = '0;
        if (i_nri_container_valid) begin
            nri_ok  = 1'b1;
            nri_val = NRI_W'(cont_val);
        end else if (i_identity_is_tmsi && bitlen != '0) begin
            nri_ok  = 1'b1;
            nri_val = tmsi_shifted[NRI_W-1:0] & tmsi_mask[NRI_W-1:0];
        end
        if (i_from_other_plmn) begin
            nri_ok = 1'b0;
        end
    end

    assign null_first = i_cfg.null_nri_range[NRI_W-1:0];
    assign null_last  = i_cfg.null_nri_range[2*NRI_W-1:NRI_W];

    assign o_nri.valid   = nri_ok;
    assign o_nri.value   = nri_val;
    assign o_nri.is_null = nri_ok && i_cfg.null_nri_range[NULL_RANGE_W-1]
                           && nri_val >= null_first && nri_val <= null_last;

endmodule

### rtl/crrs_link_pick.sv
// ----------------------------------------------------------------------------
// crrs_link_pick
// Chooses a link by NRI range match, else by round-robin from a pointer.
// ----------------------------------------------------------------------------
module crrs_link_pick (
    input  crrs_pkg::t_cfg                   i_cfg,
    input  crrs_pkg::t_nri                   i_nri,
    input  logic                             i_is_emergency,
    input  logic [crrs_pkg::NUM_LINKS-1:0]   i_link_ready_mask,
    input  logic [crrs_pkg::PTR_W-1:0]       i_ptr,
    output crrs_pkg::t_pick                  o_pick
);
    import crrs_pkg::*;

    logic [NUM_LINKS-1:0] match;
    logic [NUM_LINKS-1:0] usable;
    logic [NUM_LINKS-1:0] nri_hit;
    logic [NUM_LINKS-1:0] rr_ok;
    logic [NUM_LINKS-1:0] lost;
    logic                 hit_seen;
    logic                 hit_found;
    logic [LINK_W-1:0]    hit_idx;
    logic                 next_found;
    logic [LINK_W-1:0]    next_idx;
    logic                 first_found;
    logic [LINK_W-1:0]    first_idx;

    // Per-link qualification, all links in parallel
    always_comb begin
        for (int i = 0; i < NUM_LINKS; i++) begin
            match[i]   = i_nri.valid && i_cfg.link_nri_enable[i]
                         && i_nri.value >= i_cfg.link_nri_first[NRI_W*i +: NRI_W]
                         && i_nri.value <= i_cfg.link_nri_last[NRI_W*i +: NRI_W];
            usable[i]  = i_cfg.link_present_mask[i] && i_link_ready_mask[i]
                         && (!i_is_emergency || i_cfg.allow_emerg_mask[i]);
            nri_hit[i] = usable[i] && match[i] && !i_nri.is_null;
            rr_ok[i]   = usable[i] && i_cfg.allow_attach_mask[i];
        end
    end

    // Priority encode: NRI hit, next round-robin at/above pointer, lowest round-robin
    always_comb begin
        hit_seen    = 1'b0;
        hit_found   = 1'b0;
        hit_idx     = '0;
        next_found  = 1'b0;
        next_idx    = '0;
        first_found = 1'b0;
        first_idx   = '0;
        lost        = '0;
        for (int i = 0; i < NUM_LINKS; i++) begin
            // Links after the NRI hit are never marked lost
            if (!hit_seen) begin
                lost[i] = i_cfg.link_present_mask[i] && !usable[i] && match[i];
            end
            if (nri_hit[i] && !hit_found) begin
                hit_found = 1'b1;
                hit_idx   = LINK_W'(i);
            end
            hit_seen = hit_seen || nri_hit[i];
            if (rr_ok[i] && !first_found) begin
                first_found = 1'b1;
                first_idx   = LINK_W'(i);
            end
            if (rr_ok[i] && !next_found && PTR_W'(i) >= i_ptr) begin
                next_found = 1'b1;
                next_idx   = LINK_W'(i);
            end
        end
    end

    always_comb begin
        o_pick.lost_mask = lost;
        o_pick.by_nri    = hit_found;
        o_pick.found     = hit_found || first_found;
        if (hit_found) begin
            o_pick.link = hit_idx;
        end else if (next_found) begin
            o_pick.link = next_idx;
        end else begin
            o_pick.link = first_idx;
        end
    end

endmodule
